@@ design/ira_pkg.sv @@
// Shared types, codes and segment programs for the I2C register access master.
// No dependencies; used by ira_step, the top level and the testbench.
package ira_pkg;

    // Command codes on the request channel
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Segment kinds
    localparam logic [2:0] K_END   = 3'd0;
    localparam logic [2:0] K_START = 3'd1;
    localparam logic [2:0] K_WBYTE = 3'd2;
    localparam logic [2:0] K_ACK   = 3'd3;
    localparam logic [2:0] K_STOP  = 3'd4;
    localparam logic [2:0] K_RBYTE = 3'd5;
    localparam logic [2:0] K_PAD   = 3'd6;

    // Byte sources for a write-byte segment
    localparam logic [1:0] SRC_ADDR_W = 2'd0;
    localparam logic [1:0] SRC_REG    = 2'd1;
    localparam logic [1:0] SRC_VAL    = 2'd2;
    localparam logic [1:0] SRC_ADDR_R = 2'd3;

    localparam logic [6:0] SLAVE_ADDRESS_RESET = 7'd104;

    typedef struct packed {
        logic [1:0] src;
        logic [2:0] kind;
    } seg_t;

    // Sequencer state
    typedef struct packed {
        logic [6:0] phase_step;    // {segment, quantum}
        logic [3:0] bit_position;
        logic [7:0] shift_byte;
        logic       read_mode;
        logic [7:0] held_register;
        logic [7:0] held_value;
        logic [7:0] received_byte;
        logic       nack_flag;
    } state_t;

    // One result word
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_value;
        logic       nack_seen;
    } rsp_word_t;

    // Segment program: write and read transactions
    function automatic seg_t seg_entry(input logic read_mode, input logic [5:0] seg);
        seg_t e;
        e = '{src: SRC_ADDR_W, kind: K_END};
        if (!read_mode)
        begin
            unique case (seg)
                6'd1:    e = '{src: SRC_ADDR_W, kind: K_START};
                6'd2:    e = '{src: SRC_ADDR_W, kind: K_WBYTE};
                6'd3:    e = '{src: SRC_ADDR_W, kind: K_ACK};
                6'd4:    e = '{src: SRC_REG,    kind: K_WBYTE};
                6'd5:    e = '{src: SRC_ADDR_W, kind: K_ACK};
                6'd6:    e = '{src: SRC_VAL,    kind: K_WBYTE};
                6'd7:    e = '{src: SRC_ADDR_W, kind: K_ACK};
                6'd8:    e = '{src: SRC_ADDR_W, kind: K_STOP};
                default: e = '{src: SRC_ADDR_W, kind: K_END};
            endcase
        end
        else
        begin
            unique case (seg)
                6'd1:    e = '{src: SRC_ADDR_W, kind: K_START};
                6'd2:    e = '{src: SRC_ADDR_W, kind: K_WBYTE};
                6'd3:    e = '{src: SRC_ADDR_W, kind: K_ACK};
                6'd4:    e = '{src: SRC_REG,    kind: K_WBYTE};
                6'd5:    e = '{src: SRC_ADDR_W, kind: K_ACK};
                6'd6:    e = '{src: SRC_ADDR_W, kind: K_STOP};
                6'd7:    e = '{src: SRC_ADDR_W, kind: K_START};
                6'd8:    e = '{src: SRC_ADDR_R, kind: K_WBYTE};
                6'd9:    e = '{src: SRC_ADDR_W, kind: K_ACK};
                6'd10:   e = '{src: SRC_ADDR_W, kind: K_RBYTE};
                6'd11:   e = '{src: SRC_ADDR_W, kind: K_PAD};
                6'd12:   e = '{src: SRC_ADDR_W, kind: K_STOP};
                default: e = '{src: SRC_ADDR_W, kind: K_END};
            endcase
        end
        return e;
    endfunction

    // Quanta per segment kind
    function automatic logic [2:0] seg_length(input logic [2:0] kind);
        logic [2:0] len;
        unique case (kind)
            K_START: len = 3'd2;
            K_WBYTE: len = 3'd3;
            K_ACK:   len = 3'd4;
            K_STOP:  len = 3'd3;
            K_RBYTE: len = 3'd3;
            default: len = 3'd1;
        endcase
        return len;
    endfunction

endpackage

@@ design/ira_if.sv @@
// Handshake channels of the I2C register access master: request, result, config.
// Depends on no package; the widths are given directly.
interface ira_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] register_index;
    logic [7:0] write_value;
    logic       sda_line;

    modport source (output valid, command, register_index, write_value, sda_line,
                    input ready);
    modport sink   (input valid, command, register_index, write_value, sda_line,
                    output ready);
endinterface

interface ira_rsp_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic       nack_seen;

    modport source (output valid, scl_level, sda_level, busy_res, done_res,
                    read_value, nack_seen, input ready);
    modport sink   (input valid, scl_level, sda_level, busy_res, done_res,
                    read_value, nack_seen, output ready);
endinterface

interface ira_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] slave_address;

    modport source (output valid, slave_address, input ready);
    modport sink   (input valid, slave_address, output ready);
endinterface

@@ design/ira_step.sv @@
// One bus quantum of the I2C sequencer: next state and line levels.
// Purely combinational; depends on ira_pkg for state, result and programs.
module ira_step
(
    input  ira_pkg::state_t    st,
    input  logic [1:0]         command,
    input  logic [7:0]         register_index,
    input  logic [7:0]         write_value,
    input  logic               sda_line,
    input  logic [6:0]         slave_address,
    output ira_pkg::state_t    st_next,
    output ira_pkg::rsp_word_t res
);
    import ira_pkg::*;

    always_comb
    begin
        state_t     s;
        logic [5:0] seg;
        logic [5:0] nxt;
        logic [1:0] q;
        seg_t       ent;
        seg_t       nent;
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;

        s    = st;
        scl  = 1'b1;
        sda  = 1'b1;
        busy = 1'b0;
        done = 1'b0;

        // Start a transaction from idle
        if (s.phase_step == '0 && (command == CMD_WRITE || command == CMD_READ))
        begin
            s.read_mode     = (command == CMD_READ);
            s.held_register = register_index;
            s.held_value    = write_value;
            s.nack_flag     = 1'b0;
            s.bit_position  = '0;
            s.phase_step    = 7'd4;
        end

        seg  = {1'b0, s.phase_step[6:2]};
        q    = s.phase_step[1:0];
        nxt  = seg + 6'd1;
        ent  = seg_entry(s.read_mode, seg);
        nent = seg_entry(s.read_mode, nxt);

        if (s.phase_step != '0)
        begin
            if (ent.kind == K_END)
            begin
                s.phase_step = '0;
            end
            else
            begin
                busy = 1'b1;
                // Line levels per segment kind and quantum
                unique case (ent.kind)
                    K_START:
                    begin
                        sda = (q == 2'd0);
                    end
                    K_WBYTE:
                    begin
                        sda = s.shift_byte[7];
                        scl = (q == 2'd1);
                        if (q == 2'd2)
                        begin
                            s.shift_byte = {s.shift_byte[6:0], 1'b0};
                        end
                    end
                    K_ACK:
                    begin
                        scl = (q == 2'd1 || q == 2'd2);
                        if (q == 2'd1 && sda_line)
                        begin
                            s.nack_flag = 1'b1;
                        end
                    end
                    K_STOP:
                    begin
                        scl = (q != 2'd0);
                        sda = (q == 2'd2);
                    end
                    K_RBYTE:
                    begin
                        scl = (q != 2'd2);
                        if (q == 2'd1)
                        begin
                            s.shift_byte = {s.shift_byte[6:0], sda_line};
                        end
                    end
                    default:
                    begin
                        scl = 1'b0;
                    end
                endcase

                // Advance quantum, bit or segment
                if (({1'b0, q} + 3'd1) < seg_length(ent.kind))
                begin
                    s.phase_step = s.phase_step + 7'd1;
                end
                else if ((ent.kind == K_WBYTE || ent.kind == K_RBYTE) &&
                         s.bit_position < 4'd7)
                begin
                    s.bit_position = s.bit_position + 4'd1;
                    s.phase_step   = {seg[4:0], 2'b00};
                end
                else
                begin
                    if (ent.kind == K_RBYTE)
                    begin
                        s.received_byte = s.shift_byte;
                    end
                    s.bit_position = '0;
                    if (nent.kind == K_END)
                    begin
                        s.phase_step = '0;
                        done         = 1'b1;
                    end
                    else
                    begin
                        s.phase_step = {nxt[4:0], 2'b00};
                        if (nent.kind == K_WBYTE)
                        begin
                            unique case (nent.src)
                                SRC_ADDR_W: s.shift_byte = {slave_address, 1'b0};
                                SRC_REG:    s.shift_byte = s.held_register;
                                SRC_VAL:    s.shift_byte = s.held_value;
                                default:    s.shift_byte = {slave_address, 1'b1};
                            endcase
                        end
                        else if (nent.kind == K_RBYTE)
                        begin
                            s.shift_byte = '0;
                        end
                    end
                end
            end
        end

        st_next        = s;
        res.scl_level  = scl;
        res.sda_level  = sda;
        res.busy_res   = busy;
        res.done_res   = done;
        res.read_value = s.received_byte;
        res.nack_seen  = s.nack_flag;
    end

endmodule

@@ design/i2c_register_access_master.sv @@
// I2C register access master: one bus quantum per word, result valid in the cycle after
// request accept, throughput 1 word per cycle unless the result is stalled (the sequencer
// step is a single combinational pass between the state and result registers).
// A request is taken while the result register is empty or being drained.
// Reset (rst_n low, asynchronous) returns the sequencer to idle, clears the
// flags and held bytes, and sets the slave address to 104.
module i2c_register_access_master
(
    input  logic        clk,
    input  logic        rst_n,
    ira_req_if.sink     req,
    ira_rsp_if.source   rsp,
    ira_cfg_if.sink     cfg
);
    import ira_pkg::*;

    state_t     st_reg;
    state_t     st_next;
    rsp_word_t  res_reg;
    rsp_word_t  res_next;
    logic       out_valid_reg;
    logic [6:0] slave_address_reg;
    logic       accept;

    // Handshake
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    // Slave address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= SLAVE_ADDRESS_RESET;
        end
        else if (cfg.valid)
        begin
            slave_address_reg <= cfg.slave_address;
        end
    end

    ira_step u_step
    (
        .st             (st_reg),
        .command        (req.command),
        .register_index (req.register_index),
        .write_value    (req.write_value),
        .sda_line       (req.sda_line),
        .slave_address  (slave_address_reg),
        .st_next        (st_next),
        .res            (res_next)
    );

    // Sequencer state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                st_reg        <= st_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.scl_level  = res_reg.scl_level;
    assign rsp.sda_level  = res_reg.sda_level;
    assign rsp.busy_res   = res_reg.busy_res;
    assign rsp.done_res   = res_reg.done_res;
    assign rsp.read_value = res_reg.read_value;
    assign rsp.nack_seen  = res_reg.nack_seen;

    // A completed stop is always part of a transaction
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.done_res) |-> res_reg.busy_res)
        else $error("done without busy");

    // Idle with no start command stays idle
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && st_reg.phase_step == '0 &&
         !(req.command == CMD_WRITE || req.command == CMD_READ))
        |=> (st_reg.phase_step == '0))
        else $error("left idle without a start command");

    // A start clears the flag and enters the second start quantum
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && st_reg.phase_step == '0 &&
         (req.command == CMD_WRITE || req.command == CMD_READ))
        |=> (!st_reg.nack_flag && st_reg.phase_step == 7'd5))
        else $error("bad transaction start");

    // Bit counter never passes the last bit of a byte
    a_bitpos: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.bit_position <= 4'd7)
        else $error("bit position out of range");

endmodule

@@ tb/ira_bus_checker.sv @@
`timescale 1ns / 1ps
// Checker for the I2C register access master: watches the request, result and
// config channels, predicts every bus quantum and compares it word by word.
// Depends on ira_pkg and the channel interfaces in ira_if.sv.
module ira_bus_checker
(
    input  logic  clk,
    input  logic  rst_n,
    ira_req_if    req,
    ira_rsp_if    rsp,
    ira_cfg_if    cfg,
    output int    words_due,
    output int    mismatches
);
    import ira_pkg::*;

    // Predicted sequencer state
    logic [6:0] bus_addr    = SLAVE_ADDRESS_RESET;
    logic [6:0] step_pos    = '0;
    logic [3:0] bit_cnt     = '0;
    logic [7:0] shifter     = '0;
    logic       rd_mode     = 1'b0;
    logic [7:0] latched_reg = '0;
    logic [7:0] latched_val = '0;
    logic [7:0] rx_byte     = '0;
    logic       nack_flag   = 1'b0;

    rsp_word_t  bus_words_due[$];
    rsp_word_t  want;
    rsp_word_t  got;
    int         fail_cnt = 0;

    assign mismatches = fail_cnt;

    // Segment sequence of a write and of a read transaction
    function automatic seg_t program_entry(input logic rd, input logic [5:0] seg);
        seg_t e;
        e.kind = K_END;
        e.src  = SRC_ADDR_W;
        case (seg)
            6'd1: e.kind = K_START;
            6'd2: e.kind = K_WBYTE;
            6'd3: e.kind = K_ACK;
            6'd4:
            begin
                e.kind = K_WBYTE;
                e.src  = SRC_REG;
            end
            6'd5: e.kind = K_ACK;
            6'd6:
            begin
                e.kind = rd ? K_STOP : K_WBYTE;
                e.src  = rd ? SRC_ADDR_W : SRC_VAL;
            end
            6'd7: e.kind = rd ? K_START : K_ACK;
            6'd8:
            begin
                e.kind = rd ? K_WBYTE : K_STOP;
                e.src  = rd ? SRC_ADDR_R : SRC_ADDR_W;
            end
            6'd9:  if (rd) e.kind = K_ACK;
            6'd10: if (rd) e.kind = K_RBYTE;
            6'd11: if (rd) e.kind = K_PAD;
            6'd12: if (rd) e.kind = K_STOP;
            default: ;
        endcase
        return e;
    endfunction

    function automatic int quanta_of(input logic [2:0] kind);
        case (kind)
            K_START: return 2;
            K_WBYTE: return 3;
            K_ACK:   return 4;
            K_STOP:  return 3;
            K_RBYTE: return 3;
            default: return 1;
        endcase
    endfunction

    // Byte loaded into the shifter at the start of a write-byte segment
    function automatic logic [7:0] byte_from(input logic [1:0] src);
        case (src)
            SRC_ADDR_W: return {bus_addr, 1'b0};
            SRC_REG:    return latched_reg;
            SRC_VAL:    return latched_val;
            default:    return {bus_addr, 1'b1};
        endcase
    endfunction

    // One bus quantum: line drives and flags, updating the predicted state
    function automatic rsp_word_t advance_bus_quantum(input logic [1:0] cmd,
                                                      input logic [7:0] reg_idx,
                                                      input logic [7:0] wr_val,
                                                      input logic       sda_in);
        rsp_word_t  w;
        seg_t       cur;
        seg_t       nxt;
        logic [5:0] seg;
        logic [5:0] nseg;
        logic [1:0] q;
        w = '0;
        w.scl_level = 1'b1;
        w.sda_level = 1'b1;

        // start only from idle; anything else is a plain tick
        if (step_pos == '0 && (cmd == CMD_WRITE || cmd == CMD_READ))
        begin
            rd_mode     = (cmd == CMD_READ);
            latched_reg = reg_idx;
            latched_val = wr_val;
            nack_flag   = 1'b0;
            bit_cnt     = '0;
            step_pos    = 7'd4;
        end

        if (step_pos != '0)
        begin
            seg = {1'b0, step_pos[6:2]};
            q   = step_pos[1:0];
            cur = program_entry(rd_mode, seg);
            if (cur.kind == K_END)
                step_pos = '0;
            else
            begin
                w.busy_res = 1'b1;
                case (cur.kind)
                    K_START: w.sda_level = (q == 2'd0);
                    K_WBYTE:
                    begin
                        w.sda_level = shifter[7];
                        w.scl_level = (q == 2'd1);
                        if (q == 2'd2)
                            shifter = {shifter[6:0], 1'b0};
                    end
                    K_ACK:
                    begin
                        w.scl_level = (q == 2'd1 || q == 2'd2);
                        if (q == 2'd1 && sda_in)
                            nack_flag = 1'b1;
                    end
                    K_STOP:
                    begin
                        w.scl_level = (q != 2'd0);
                        w.sda_level = (q == 2'd2);
                    end
                    K_RBYTE:
                    begin
                        w.scl_level = (q != 2'd2);
                        if (q == 2'd1)
                            shifter = {shifter[6:0], sda_in};
                    end
                    default: w.scl_level = 1'b0;
                endcase

                // next quantum, next bit, or next segment
                if (int'(q) + 1 < quanta_of(cur.kind))
                    step_pos = step_pos + 7'd1;
                else if ((cur.kind == K_WBYTE || cur.kind == K_RBYTE) && bit_cnt < 4'd7)
                begin
                    bit_cnt  = bit_cnt + 4'd1;
                    step_pos = {seg[4:0], 2'b00};
                end
                else
                begin
                    nseg = seg + 6'd1;
                    nxt  = program_entry(rd_mode, nseg);
                    if (cur.kind == K_RBYTE)
                        rx_byte = shifter;
                    bit_cnt = '0;
                    if (nxt.kind == K_END)
                    begin
                        step_pos   = '0;
                        w.done_res = 1'b1;
                    end
                    else
                    begin
                        step_pos = {nseg[4:0], 2'b00};
                        if (nxt.kind == K_WBYTE)
                            shifter = byte_from(nxt.src);
                        else if (nxt.kind == K_RBYTE)
                            shifter = '0;
                    end
                end
            end
        end

        w.read_value = rx_byte;
        w.nack_seen  = nack_flag;
        return w;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    // Monitor: results are checked before new requests are predicted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_addr    = SLAVE_ADDRESS_RESET;
            step_pos    = '0;
            bit_cnt     = '0;
            shifter     = '0;
            rd_mode     = 1'b0;
            latched_reg = '0;
            latched_val = '0;
            rx_byte     = '0;
            nack_flag   = 1'b0;
            bus_words_due.delete();
            words_due  <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.scl_level  = rsp.scl_level;
                got.sda_level  = rsp.sda_level;
                got.busy_res   = rsp.busy_res;
                got.done_res   = rsp.done_res;
                got.read_value = rsp.read_value;
                got.nack_seen  = rsp.nack_seen;
                if (bus_words_due.size() == 0)
                begin
                    $error("result word with no request outstanding");
                    fail_cnt++;
                end
                else
                begin
                    want = bus_words_due.pop_front();
                    check_field("scl_level", want.scl_level, got.scl_level);
                    check_field("sda_level", want.sda_level, got.sda_level);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("read_value", want.read_value, got.read_value);
                    check_field("nack_seen", want.nack_seen, got.nack_seen);
                end
            end
            if (cfg.valid && cfg.ready)
                bus_addr = cfg.slave_address;
            if (req.valid && req.ready)
                bus_words_due.push_back(advance_bus_quantum(req.command, req.register_index,
                                                            req.write_value, req.sda_line));
            words_due <= bus_words_due.size();
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Top of the I2C register access master testbench: clock, reset, request and
// config stimulus, result backpressure and verdict. Uses ira_pkg, ira_if.sv, ira_bus_checker.
module tb;
    import ira_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         STALL_LIMIT = 3000;
    localparam int         DRAIN_LIMIT = 5000;
    localparam int         SDA_LOW     = 0;
    localparam int         SDA_HIGH    = 1;
    localparam int         SDA_RANDOM  = 2;

    logic clk = 1'b0;
    logic rst_n;
    int   words_due;
    int   mismatches;
    bit   no_idle  = 1'b0;
    int   sda_mode = SDA_RANDOM;
    int   stall_cycles;

    ira_req_if req_ch ();
    ira_rsp_if rsp_ch ();
    ira_cfg_if cfg_ch ();

    i2c_register_access_master i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    ira_bus_checker i_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg        (cfg_ch),
        .words_due  (words_due),
        .mismatches (mismatches)
    );

    always #4 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic pick_sda();
        if (sda_mode == SDA_LOW)
            return 1'b0;
        else if (sda_mode == SDA_HIGH)
            return 1'b1;
        return 1'($urandom_range(0, 1));
    endfunction

    // One request word; valid stays up across back-to-back words
    task automatic send_quantum(input logic [1:0] cmd, input logic [7:0] reg_idx,
                                input logic [7:0] wr_val, input logic sda);
        int gap;
        gap = pick_gap(no_idle);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.command        <= cmd;
        req_ch.register_index <= reg_idx;
        req_ch.write_value    <= wr_val;
        req_ch.sda_line       <= sda;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    task automatic send_ticks(input int n);
        repeat (n)
            send_quantum(CMD_TICK, 8'($urandom), 8'($urandom), pick_sda());
    endtask

    // Hold requests until every predicted word has come back
    task automatic drain_results(input int limit);
        int n;
        n = 0;
        req_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
            n++;
        end
        while (words_due != 0 && n < limit);
    endtask

    task automatic write_slave_address(input logic [6:0] addr);
        drain_results(DRAIN_LIMIT);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.slave_address <= addr;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result backpressure: random stalls with occasional stall-free stretches
    initial
    begin : result_sink
        int hold;
        int gap;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 8);
            rsp_ch.ready <= 1'b1;
            repeat (hold) @(posedge clk);
            gap = pick_gap(1'b0);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Watchdog on cycles with no handshake on any channel
    initial
    begin : watchdog
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        int       r;
        logic [1:0] cmd;
        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.command        <= CMD_TICK;
        req_ch.register_index <= '0;
        req_ch.write_value    <= '0;
        req_ch.sda_line       <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.slave_address  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle ticks, the unused command code acts as a tick
        send_quantum(CMD_TICK, 8'h00, 8'h00, 1'b0);
        send_quantum(CMD_UNUSED, 8'hFF, 8'hFF, 1'b1);

        // write at reset address, all acks, read command while busy is ignored
        sda_mode = SDA_LOW;
        send_quantum(CMD_WRITE, 8'hFF, 8'h00, 1'b0);
        send_quantum(CMD_READ, 8'h55, 8'hAA, 1'b0);
        send_ticks(88);

        // read with every sample high: nack flagged and 0xff read back
        sda_mode = SDA_HIGH;
        send_quantum(CMD_READ, 8'h00, 8'hFF, 1'b1);
        send_ticks(119);

        sda_mode = SDA_RANDOM;
        send_quantum(CMD_WRITE, 8'h00, 8'hFF, pick_sda());
        send_ticks(89);

        // address changed in the middle of a read, before the restart
        send_quantum(CMD_READ, 8'hA5, 8'h5A, pick_sda());
        send_ticks(30);
        write_slave_address(7'd0);
        send_ticks(100);
        write_slave_address(7'h7F);
        send_quantum(CMD_WRITE, 8'h3C, 8'hC3, pick_sda());
        send_ticks(89);

        // random phases, each with its own address, idling and line behavior
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                1:       write_slave_address(7'd0);
                2:       write_slave_address(7'h7F);
                3:       write_slave_address(SLAVE_ADDRESS_RESET);
                default: write_slave_address(7'($urandom));
            endcase
            no_idle  = (ph % 4 == 3);
            r        = $urandom_range(0, 9);
            sda_mode = (r < 2) ? SDA_LOW : (r < 3) ? SDA_HIGH : SDA_RANDOM;
            for (int k = 0; k < 54; k++)
            begin
                if (ph == 5 && k == 27)
                    drain_results(DRAIN_LIMIT);
                r   = $urandom_range(0, 99);
                cmd = (r < 92) ? CMD_TICK : 2'($urandom_range(0, 3));
                send_quantum(cmd, 8'($urandom), 8'($urandom), pick_sda());
            end
        end
        no_idle = 1'b0;

        drain_results(DRAIN_LIMIT);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && words_due == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
